@@ rtl/core/i2c_dbw_pkg.sv @@
// Shared constants and types for the display byte writer core.
package i2c_dbw_pkg;

   localparam int unsigned PhaseWidth = 16;
   localparam int unsigned RetryWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 16;

   // control byte that follows the address
   localparam logic [7:0] CtrlCmd = 8'h00;
   localparam logic [7:0] CtrlData = 8'h40;

   localparam logic [7:0] AddressReset = 8'h78;
   localparam logic [PhaseWidth-1:0] PhaseReset = 16'd1;
   localparam logic [RetryWidth-1:0] RetryLimitReset = 8'd0;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CsrAddressByte = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPhaseTicks = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrAckRetryLimit = 2'd2;

   // one result beat
   typedef struct packed {
      logic scl;
      logic sda_out;
      logic busy_res;
      logic done_res;
      logic ack_failed;
   } rsp_type;

endpackage

@@ rtl/core/i2c_display_byte_writer_core.sv @@
// I2C display write master: line sequencer with result register and skid stage.
//
// Each req beat is one timing tick of the bus sequencer. A beat with
// req_start_req high while idle latches req_payload and req_is_data and
// starts a transfer: start condition, address byte, control byte (0x00
// command, 0x40 data), payload MSB first, then stop. Every line level is
// held for phase_ticks ticks. req_sda_in is sampled at the end of each ack
// clock high phase; a NACK repeats the ack clock, bounded by
// ack_retry_limit (0 = no bound), after which ack_failed pulses and a stop
// follows.
// Every req beat gives exactly one rsp beat with the line levels and status
// for that tick. The sequencer updates in the cycle a beat is accepted and
// the result is registered for rsp; one beat per cycle is sustained while
// rsp_ready stays high. A stalled rsp side fills the output register and
// then the skid register; req_ready drops only once both hold a beat.
// The csr port writes a register at each edge with csr_we high; writes are
// taken at once. Reset (synchronous) idles the sequencer with both lines
// released and restores the register defaults.
module i2c_display_byte_writer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_start_req,
   input  logic [7:0]                            req_payload,
   input  logic                                  req_is_data,
   input  logic                                  req_sda_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_scl,
   output logic                                  rsp_sda_out,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic                                  rsp_ack_failed,
   input  logic                                  csr_we,
   input  logic [i2c_dbw_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [i2c_dbw_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import i2c_dbw_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'd0,
      ST_ST_A     = 5'd1,
      ST_ST_B     = 5'd2,
      ST_ST_C     = 5'd3,
      ST_BIT_LOW  = 5'd4,
      ST_BIT_DATA = 5'd5,
      ST_BIT_HIGH = 5'd6,
      ST_BYTE_END = 5'd7,
      ST_ACK_LOW  = 5'd8,
      ST_ACK_REL  = 5'd9,
      ST_ACK_HIGH = 5'd10,
      ST_ACK_OK   = 5'd11,
      ST_ACK_NACK = 5'd12,
      ST_ACK_FAIL = 5'd13,
      ST_SP_A     = 5'd14,
      ST_SP_B     = 5'd15,
      ST_SP_C     = 5'd16
   } step_type;

   // configuration registers
   logic [7:0]            address_ff;
   logic [PhaseWidth-1:0] phase_ticks_ff;
   logic [RetryWidth-1:0] retry_limit_ff;

   // sequencer state
   step_type              step_ff, step_in;
   logic [1:0]            byte_ff, byte_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            held_payload_ff, held_payload_in;
   logic                  held_is_data_ff, held_is_data_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [RetryWidth-1:0] retry_ff, retry_in;
   logic                  scl_line_ff, scl_line_in;
   logic                  sda_line_ff, sda_line_in;

   // result register and skid stage
   logic    out_valid_ff;
   rsp_type out_ff;
   logic    skid_valid_ff;
   rsp_type skid_ff;

   logic                  req_fire;
   logic                  entering;
   logic                  done_now;
   logic                  failed_now;
   logic [PhaseWidth-1:0] hold_ticks;
   logic [PhaseWidth-1:0] phase_inc;
   rsp_type               rsp_new;

   assign req_ready = ~skid_valid_ff;
   assign req_fire  = req_valid & req_ready;

   // a zero phase setting behaves as one tick
   assign hold_ticks = (phase_ticks_ff == '0) ? PhaseWidth'(1) : phase_ticks_ff;
   assign phase_inc  = phase_ff + PhaseWidth'(1);

   // next step and counters for one tick
   always_comb begin
      step_in         = step_ff;
      byte_in         = byte_ff;
      bit_in          = bit_ff;
      shift_in        = shift_ff;
      held_payload_in = held_payload_ff;
      held_is_data_in = held_is_data_ff;
      phase_in        = phase_ff;
      retry_in        = retry_ff;
      entering        = 1'b0;
      done_now        = 1'b0;
      failed_now      = 1'b0;

      if (step_ff == ST_IDLE) begin
         if (req_start_req) begin
            held_payload_in = req_payload;
            held_is_data_in = req_is_data;
            byte_in         = '0;
            bit_in          = '0;
            retry_in        = '0;
            step_in         = ST_ST_A;
            entering        = 1'b1;
         end
      end else begin
         phase_in = phase_inc;
         if (phase_inc >= hold_ticks) begin
            entering = 1'b1;
            case (step_ff)
               ST_ST_A: begin
                  step_in = ST_ST_B;
               end
               ST_ST_B: begin
                  step_in = ST_ST_C;
               end
               ST_ST_C: begin
                  shift_in = address_ff;
                  bit_in   = '0;
                  step_in  = ST_BIT_LOW;
               end
               ST_BIT_LOW: begin
                  step_in = ST_BIT_DATA;
               end
               ST_BIT_DATA: begin
                  step_in = ST_BIT_HIGH;
               end
               ST_BIT_HIGH: begin
                  if (bit_ff == 3'd7) begin
                     bit_in  = '0;
                     step_in = ST_BYTE_END;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     shift_in = {shift_ff[6:0], 1'b0};
                     step_in  = ST_BIT_LOW;
                  end
               end
               ST_BYTE_END: begin
                  step_in = ST_ACK_LOW;
               end
               ST_ACK_LOW: begin
                  step_in = ST_ACK_REL;
               end
               ST_ACK_REL: begin
                  step_in = ST_ACK_HIGH;
               end
               ST_ACK_HIGH: begin
                  if (!req_sda_in) begin
                     step_in = ST_ACK_OK;
                  end else if (retry_limit_ff == '0 || retry_ff < retry_limit_ff) begin
                     if (retry_ff != '1) begin
                        retry_in = retry_ff + RetryWidth'(1);
                     end
                     step_in = ST_ACK_NACK;
                  end else begin
                     failed_now = 1'b1;
                     step_in    = ST_ACK_FAIL;
                  end
               end
               ST_ACK_OK: begin
                  retry_in = '0;
                  if (byte_ff >= 2'd2) begin
                     step_in = ST_SP_A;
                  end else begin
                     byte_in  = byte_ff + 2'd1;
                     // byte 1 is the control byte, byte 2 the payload
                     if (byte_ff == 2'd0) begin
                        shift_in = held_is_data_ff ? CtrlData : CtrlCmd;
                     end else begin
                        shift_in = held_payload_ff;
                     end
                     bit_in  = '0;
                     step_in = ST_BIT_LOW;
                  end
               end
               ST_ACK_NACK: begin
                  step_in = ST_ACK_LOW;
               end
               ST_ACK_FAIL: begin
                  step_in = ST_SP_A;
               end
               ST_SP_A: begin
                  step_in = ST_SP_B;
               end
               ST_SP_B: begin
                  step_in = ST_SP_C;
               end
               ST_SP_C: begin
                  done_now = 1'b1;
                  step_in  = ST_IDLE;
               end
               default: begin
                  step_in = ST_IDLE;
               end
            endcase
         end
      end

      if (entering) begin
         phase_in = '0;
      end
   end

   // line levels change only on entry to a step
   always_comb begin
      scl_line_in = scl_line_ff;
      sda_line_in = sda_line_ff;
      if (entering) begin
         case (step_in)
            ST_ST_A: begin
               scl_line_in = 1'b1;
               sda_line_in = 1'b1;
            end
            ST_ST_B:     sda_line_in = 1'b0;
            ST_ST_C:     scl_line_in = 1'b0;
            ST_BIT_LOW:  scl_line_in = 1'b0;
            ST_BIT_DATA: sda_line_in = shift_in[7];
            ST_BIT_HIGH: scl_line_in = 1'b1;
            ST_BYTE_END: scl_line_in = 1'b0;
            ST_ACK_LOW:  scl_line_in = 1'b0;
            ST_ACK_REL:  sda_line_in = 1'b1;
            ST_ACK_HIGH: scl_line_in = 1'b1;
            ST_ACK_OK, ST_ACK_NACK, ST_ACK_FAIL: begin
               scl_line_in = 1'b0;
            end
            ST_SP_A:     sda_line_in = 1'b0;
            ST_SP_B:     scl_line_in = 1'b1;
            ST_SP_C:     sda_line_in = 1'b1;
            default: begin
               scl_line_in = 1'b1;
               sda_line_in = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      rsp_new.scl        = scl_line_in;
      rsp_new.sda_out    = sda_line_in;
      rsp_new.busy_res   = (step_in != ST_IDLE);
      rsp_new.done_res   = done_now;
      rsp_new.ack_failed = failed_now;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff     <= AddressReset;
         phase_ticks_ff <= PhaseReset;
         retry_limit_ff <= RetryLimitReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrAddressByte:   address_ff     <= csr_wdata[7:0];
            CsrPhaseTicks:    phase_ticks_ff <= csr_wdata[PhaseWidth-1:0];
            CsrAckRetryLimit: retry_limit_ff <= csr_wdata[RetryWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer state advances once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= ST_IDLE;
         byte_ff         <= '0;
         bit_ff          <= '0;
         shift_ff        <= '0;
         held_payload_ff <= '0;
         held_is_data_ff <= 1'b0;
         phase_ff        <= '0;
         retry_ff        <= '0;
         scl_line_ff     <= 1'b1;
         sda_line_ff     <= 1'b1;
      end else if (req_fire) begin
         step_ff         <= step_in;
         byte_ff         <= byte_in;
         bit_ff          <= bit_in;
         shift_ff        <= shift_in;
         held_payload_ff <= held_payload_in;
         held_is_data_ff <= held_is_data_in;
         phase_ff        <= phase_in;
         retry_ff        <= retry_in;
         scl_line_ff     <= scl_line_in;
         sda_line_ff     <= sda_line_in;
      end
   end

   // result register with skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_ready) begin
            out_ff <= rsp_new;
         end else begin
            skid_ff <= rsp_new;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_scl        = out_ff.scl;
   assign rsp_sda_out    = out_ff.sda_out;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_ack_failed = out_ff.ack_failed;

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for the display byte writer core, predicting the bus lines tick by tick.
`timescale 1ns / 1ps

module testbench;
   import i2c_dbw_pkg::*;

   // sequencer steps, in the order the line sequence walks them
   typedef enum logic [4:0] {
      SqIdle, SqStartA, SqStartB, SqStartC,
      SqBitLow, SqBitData, SqBitHigh, SqByteEnd,
      SqAckLow, SqAckRel, SqAckHigh, SqAckOk, SqAckNack, SqAckFail,
      SqStopA, SqStopB, SqStopC
   } seq_step_type;

   // one req beat = one sequencer tick
   typedef struct packed {
      logic       start_req;
      logic [7:0] payload;
      logic       is_data;
      logic       sda_in;
   } line_tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_start_req = 1'b0;
   logic [7:0]               req_payload = '0;
   logic                     req_is_data = 1'b0;
   logic                     req_sda_in = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_scl;
   logic                     rsp_sda_out;
   logic                     rsp_busy_res;
   logic                     rsp_done_res;
   logic                     rsp_ack_failed;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   i2c_display_byte_writer_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_req (req_start_req),
      .req_payload   (req_payload),
      .req_is_data   (req_is_data),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl       (rsp_scl),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_ack_failed(rsp_ack_failed),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: register shadows plus the sequencer as we expect it.
   // Initial values are the post-reset state.
   // ---------------------------------------------------------------------
   logic [7:0]            addr_reg = AddressReset;
   logic [PhaseWidth-1:0] ticks_reg = PhaseReset;
   logic [RetryWidth-1:0] retry_reg = RetryLimitReset;

   seq_step_type          seq_step = SqIdle;
   logic [1:0]            byte_no = '0;
   logic [2:0]            bit_no = '0;
   logic [7:0]            shifter = '0;
   logic [7:0]            held_byte = '0;
   logic                  held_data = 1'b0;
   logic [PhaseWidth-1:0] phase_cnt = '0;
   logic [RetryWidth-1:0] nack_cnt = '0;
   logic                  scl_lvl = 1'b1;
   logic                  sda_lvl = 1'b1;

   line_tick_type pending_ticks[$];   // filled by the stimulus, drained by the driver
   rsp_type       expected_lines[$];  // predicted line beats, oldest first
   line_tick_type next_tick;
   rsp_type       want_line;

   int   fault_count = 0;
   logic pace_jitter = 1'b1;  // random idling on both sides
   int   stall_orders = 0;    // bumped by the stimulus to ask for a long rsp hold-off
   int   stall_taken = 0;
   int   hold_left = 0;

   // Entering a step resets the phase count and sets the new line levels,
   // which show on the same tick.
   function automatic void enter_step(seq_step_type s);
      seq_step = s;
      phase_cnt = '0;
      case (s)
         SqStartA: begin
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
         end
         SqStartB, SqStopA: sda_lvl = 1'b0;
         SqStartC, SqBitLow, SqByteEnd, SqAckLow,
         SqAckOk, SqAckNack, SqAckFail: scl_lvl = 1'b0;
         SqBitData: sda_lvl = shifter[7];
         SqBitHigh, SqAckHigh, SqStopB: scl_lvl = 1'b1;
         SqAckRel, SqStopC: sda_lvl = 1'b1;
         default: begin
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
         end
      endcase
   endfunction

   // Advance the expected sequencer by one tick and return the beat it shows.
   function automatic rsp_type advance_line(line_tick_type t);
      rsp_type               r;
      logic [PhaseWidth-1:0] hold;
      r = '0;
      // a zero phase length behaves as one
      hold = (ticks_reg == '0) ? PhaseWidth'(1) : ticks_reg;
      if (seq_step == SqIdle) begin
         // start is only looked at while idle
         if (t.start_req) begin
            held_byte = t.payload;
            held_data = t.is_data;
            byte_no = '0;
            bit_no = '0;
            nack_cnt = '0;
            enter_step(SqStartA);
         end
      end else begin
         phase_cnt = phase_cnt + PhaseWidth'(1);
         if (phase_cnt >= hold) begin
            case (seq_step)
               SqStartA: enter_step(SqStartB);
               SqStartB: enter_step(SqStartC);
               SqStartC: begin
                  // address register read here, so late writes still count
                  shifter = addr_reg;
                  bit_no = '0;
                  enter_step(SqBitLow);
               end
               SqBitLow: enter_step(SqBitData);
               SqBitData: enter_step(SqBitHigh);
               SqBitHigh: begin
                  if (bit_no == 3'd7) begin
                     bit_no = '0;
                     enter_step(SqByteEnd);
                  end else begin
                     bit_no = bit_no + 3'd1;
                     shifter = shifter << 1;
                     enter_step(SqBitLow);
                  end
               end
               SqByteEnd: enter_step(SqAckLow);
               SqAckLow: enter_step(SqAckRel);
               SqAckRel: enter_step(SqAckHigh);
               SqAckHigh: begin
                  // ack sampled on the last tick of the SCL-high phase
                  if (!t.sda_in) begin
                     enter_step(SqAckOk);
                  end else if (retry_reg == '0 || nack_cnt < retry_reg) begin
                     if (nack_cnt != '1) nack_cnt = nack_cnt + RetryWidth'(1);
                     enter_step(SqAckNack);
                  end else begin
                     r.ack_failed = 1'b1;
                     enter_step(SqAckFail);
                  end
               end
               SqAckOk: begin
                  nack_cnt = '0;
                  if (byte_no >= 2'd2) begin
                     enter_step(SqStopA);
                  end else begin
                     byte_no = byte_no + 2'd1;
                     shifter = (byte_no == 2'd1) ? (held_data ? CtrlData : CtrlCmd)
                                                 : held_byte;
                     bit_no = '0;
                     enter_step(SqBitLow);
                  end
               end
               SqAckNack: enter_step(SqAckLow);
               SqAckFail: enter_step(SqStopA);
               SqStopA: enter_step(SqStopB);
               SqStopB: enter_step(SqStopC);
               SqStopC: begin
                  r.done_res = 1'b1;
                  enter_step(SqIdle);
               end
               default: enter_step(SqIdle);
            endcase
         end
      end
      r.scl = scl_lvl;
      r.sda_out = sda_lvl;
      r.busy_res = (seq_step != SqIdle);
      return r;
   endfunction

   function automatic void check_bit(string field, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", field, want, got);
         fault_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: predicts each req beat as it is taken, then offers the next
   // one unless it decides to idle this cycle.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_lines.push_back(advance_line(
               '{req_start_req, req_payload, req_is_data, req_sda_in}));
         end
         if (!req_valid || req_ready) begin
            if (pending_ticks.size() != 0 &&
                !(pace_jitter && $urandom_range(99) < 10)) begin
               next_tick = pending_ticks.pop_front();
               req_valid <= 1'b1;
               req_start_req <= next_tick.start_req;
               req_payload <= next_tick.payload;
               req_is_data <= next_tick.is_data;
               req_sda_in <= next_tick.sda_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each rsp beat against the oldest prediction; decides
   // rsp_ready for the next cycle, including long ordered hold-offs.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_lines.size() == 0) begin
               $error("rsp beat arrived with nothing expected");
               fault_count++;
            end else begin
               want_line = expected_lines.pop_front();
               check_bit("scl", want_line.scl, rsp_scl);
               check_bit("sda_out", want_line.sda_out, rsp_sda_out);
               check_bit("busy_res", want_line.busy_res, rsp_busy_res);
               check_bit("done_res", want_line.done_res, rsp_done_res);
               check_bit("ack_failed", want_line.ack_failed, rsp_ack_failed);
            end
         end
         if (stall_orders != stall_taken) begin
            stall_taken <= stall_orders;
            hold_left <= 300;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(pace_jitter && $urandom_range(99) < 10);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_tick(logic start, logic [7:0] payload, logic is_data, logic sda);
      @(negedge clock);
      pending_ticks.push_back('{start, payload, is_data, sda});
   endtask

   // sender pauses until every predicted beat has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_lines.size() != 0);
   endtask

   // keep ticking with a fixed ack level until the sequencer is back to idle
   task automatic finish_transfer(logic sda_level);
      wait_drained();
      while (seq_step != SqIdle) begin
         repeat (16) pending_ticks.push_back('{1'b0, 8'($urandom), 1'($urandom), sda_level});
         wait_drained();
      end
   endtask

   // register write; only issued with nothing in flight
   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CsrAddressByte: addr_reg = val[7:0];
         CsrPhaseTicks: ticks_reg = val;
         CsrAckRetryLimit: retry_reg = val[RetryWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed traffic: occasional starts (ignored while busy) and
   // acks with a given NACK rate; a share of pure noise on start and SDA.
   task automatic run_phase(logic [7:0] addr, logic [15:0] ticks, logic [7:0] limit,
                            int count, int start_pct, int nack_pct, int noise_pct);
      line_tick_type t;
      logic          noisy;
      write_csr(CsrAddressByte, 16'(addr));
      write_csr(CsrPhaseTicks, ticks);
      write_csr(CsrAckRetryLimit, 16'(limit));
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         noisy = ($urandom_range(99) < noise_pct);
         t.start_req = noisy ? 1'($urandom) : ($urandom_range(99) < start_pct);
         t.payload = 8'($urandom);
         t.is_data = 1'($urandom);
         t.sda_in = noisy ? 1'($urandom) : ($urandom_range(99) < nack_pct);
         pending_ticks.push_back(t);
      end
      finish_transfer(1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed, register defaults. Idle tick with fields at their tops,
      // then a data transfer of 0xFF with starts offered mid-transfer.
      push_tick(1'b0, 8'hFF, 1'b1, 1'b1);
      push_tick(1'b1, 8'hFF, 1'b1, 1'b0);
      push_tick(1'b1, 8'h00, 1'b0, 1'b1);
      push_tick(1'b1, 8'h5A, 1'b0, 1'b0);
      finish_transfer(1'b0);
      // command transfer of 0x00
      push_tick(1'b1, 8'h00, 1'b0, 1'b0);
      finish_transfer(1'b0);
      // NACKs with no retry bound: ack clock repeats until SDA is pulled low
      push_tick(1'b1, 8'hA5, 1'b1, 1'b1);
      @(negedge clock);
      repeat (80) pending_ticks.push_back('{1'b0, 8'h00, 1'b0, 1'b1});
      finish_transfer(1'b0);
      // retry bound of one: second NACK abandons the transfer, stop follows
      write_csr(CsrAckRetryLimit, 16'd1);
      write_csr(CsrAddressByte, 16'h00FF);
      push_tick(1'b1, 8'h3C, 1'b0, 1'b1);
      finish_transfer(1'b1);

      // Back-pressure: rsp held off for a long stretch while req keeps
      // coming, so both output stages fill and req_ready drops.
      @(posedge clock);
      stall_orders <= stall_orders + 1;
      run_phase(8'($urandom), 16'd1, 8'd0, 100, 25, 10, 10);

      // steady stretch: no idling on either side
      @(posedge clock);
      pace_jitter <= 1'b0;
      run_phase(8'($urandom), 16'd1, 8'd0, 80, 20, 10, 10);
      @(posedge clock);
      pace_jitter <= 1'b1;

      run_phase(8'h00, 16'd2, 8'd1, 60, 20, 35, 15);
      run_phase(8'hFF, 16'd1, 8'hFF, 60, 20, 25, 15);
      run_phase(8'($urandom), 16'd3, 8'd2, 60, 20, 45, 15);
      // longest phase: idle ticks only
      run_phase(8'($urandom), 16'hFFFF, 8'($urandom), 30, 0, 50, 0);
      run_phase(8'($urandom), 16'd1, 8'd3, 60, 25, 30, 15);

      wait_drained();
      repeat (4) @(posedge clock);
      if (expected_lines.size() != 0) begin
         $error("%0d predicted beats never arrived", expected_lines.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #2_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/i2c_dbw_pkg.sv
rtl/core/i2c_display_byte_writer_core.sv
tb/testbench.sv
